### hw/rtl/i2c_master_bit_engine_unit_macros.svh
// ----------------------------------------------------------------------------
// i2c master bit engine assertion macros
// shared property shorthands for the bit engine checks
// ----------------------------------------------------------------------------
`ifndef I2C_MASTER_BIT_ENGINE_UNIT_MACROS_SVH
`define I2C_MASTER_BIT_ENGINE_UNIT_MACROS_SVH

// same-cycle implication, disabled during reset
`define I2CM_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled during reset
`define I2CM_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hw/rtl/i2cm_pkg.sv
// ----------------------------------------------------------------------------
// i2cm_pkg
// types, codes and reset values shared by the i2c master bit engine
// ----------------------------------------------------------------------------
package i2cm_pkg;

  localparam logic [7:0]  HALF_PERIOD_RST = 8'd5;
  localparam logic [15:0] ACK_TIMEOUT_RST = 16'd100;
  localparam int          QUEUE_DEPTH     = 2;

  // request codes on the input kind field
  localparam logic [2:0] REQ_START = 3'd0;
  localparam logic [2:0] REQ_STOP  = 3'd1;
  localparam logic [2:0] REQ_WRITE = 3'd2;
  localparam logic [2:0] REQ_READ  = 3'd3;
  localparam logic [2:0] REQ_TICK  = 3'd4;

  // command codes held by the engine
  localparam logic [1:0] CMD_START = 2'd0;
  localparam logic [1:0] CMD_STOP  = 2'd1;
  localparam logic [1:0] CMD_WRITE = 2'd2;
  localparam logic [1:0] CMD_READ  = 2'd3;

  // configuration register indexes
  localparam logic CFG_HALF_PERIOD = 1'b0;
  localparam logic CFG_ACK_TIMEOUT = 1'b1;

  typedef struct packed {
    logic       is_cmd;
    logic       is_tick;
    logic [1:0] cmd;
    logic [7:0] tx_byte;
    logic       send_ack;
    logic       sda_in;
  } op_t;

  typedef struct packed {
    logic       cmd_rejected;
    logic [7:0] rx_byte;
    logic       timed_out;
    logic       got_ack;
    logic       done_res;
    logic       busy_res;
    logic       sda_drive;
    logic       scl_level;
  } res_t;

endpackage

### hw/rtl/i2cm_front.sv
// ----------------------------------------------------------------------------
// i2cm_front
// accepts input beats, sorts them into command, tick or no-op entries
// ----------------------------------------------------------------------------
module i2cm_front (
  input  logic            valid,
  output logic            ready,
  input  logic [15:0]     data,
  input  logic [2:0]      kind,
  output logic            q_push,
  output i2cm_pkg::op_t   q_op,
  input  logic            q_full
);
  import i2cm_pkg::*;

  assign ready  = !q_full;
  assign q_push = valid && !q_full;

  always_comb begin
    q_op          = '0;
    q_op.tx_byte  = data[7:0];
    q_op.send_ack = data[8];
    q_op.sda_in   = data[9];
    q_op.cmd      = kind[1:0];
    case (kind)
      REQ_START, REQ_STOP, REQ_WRITE, REQ_READ: begin
        q_op.is_cmd = 1'b1;
      end
      REQ_TICK: begin
        q_op.is_tick = 1'b1;
      end
      default: begin
        // unknown codes pass through as no-op beats
        q_op.is_cmd  = 1'b0;
      end
    endcase
  end

endmodule

### hw/rtl/i2cm_queue.sv
// ----------------------------------------------------------------------------
// i2cm_queue
// short fifo between the front and the engine
// ----------------------------------------------------------------------------
module i2cm_queue #(
  parameter int DEPTH = i2cm_pkg::QUEUE_DEPTH
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  i2cm_pkg::op_t   wr_data,
  output logic            full,
  input  logic            pop,
  output i2cm_pkg::op_t   rd_data,
  output logic            not_empty
);
  import i2cm_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  op_t              mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign full      = (count == CNT_W'(DEPTH));
  assign not_empty = (count != '0);
  assign rd_data   = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

### hw/rtl/i2cm_engine.sv
// ----------------------------------------------------------------------------
// i2cm_engine
// bit-phase sequencer for scl and sda, one queued beat per cycle while the output is not stalled
// ----------------------------------------------------------------------------
module i2cm_engine (
  input  logic            clk,
  input  logic            rst,
  input  logic [7:0]      half_period,
  input  logic [15:0]     ack_timeout,
  input  logic            q_valid,
  input  i2cm_pkg::op_t   q_op,
  output logic            q_pop,
  output logic            out_valid,
  input  logic            out_ready,
  output i2cm_pkg::res_t  out_res
);
  import i2cm_pkg::*;

  localparam logic [3:0] PH_IDLE    = 4'd0;
  localparam logic [3:0] PH_ST_A    = 4'd1;
  localparam logic [3:0] PH_ST_B    = 4'd2;
  localparam logic [3:0] PH_ST_C    = 4'd3;
  localparam logic [3:0] PH_SP_A    = 4'd4;
  localparam logic [3:0] PH_SP_B    = 4'd5;
  localparam logic [3:0] PH_SP_C    = 4'd6;
  localparam logic [3:0] PH_WR_LOW  = 4'd7;
  localparam logic [3:0] PH_WR_HIGH = 4'd8;
  localparam logic [3:0] PH_AK_LOW  = 4'd9;
  localparam logic [3:0] PH_AK_HIGH = 4'd10;
  localparam logic [3:0] PH_AK_WAIT = 4'd11;
  localparam logic [3:0] PH_AK_TAIL = 4'd12;
  localparam logic [3:0] PH_RD_LOW  = 4'd13;
  localparam logic [3:0] PH_RD_HIGH = 4'd14;

  logic [3:0]  phase, phase_next;
  logic [1:0]  cur_cmd, cur_cmd_next;
  logic [3:0]  bit_index, bit_index_next;
  logic [7:0]  shift_reg, shift_reg_next;
  logic [7:0]  phase_ticks, phase_ticks_next;
  logic [15:0] wait_ticks, wait_ticks_next;
  logic        scl_out, scl_out_next;
  logic        sda_out, sda_out_next;
  logic        ack_choice, ack_choice_next;
  logic        ack_seen, ack_seen_next;

  logic        go_enter;
  logic [3:0]  enter_ph;
  logic [7:0]  ticks_inc;
  res_t        res_next;

  assign q_pop     = q_valid && (!out_valid || out_ready);
  assign ticks_inc = phase_ticks + 8'd1;

  always_comb begin
    phase_next       = phase;
    cur_cmd_next     = cur_cmd;
    bit_index_next   = bit_index;
    shift_reg_next   = shift_reg;
    phase_ticks_next = phase_ticks;
    wait_ticks_next  = wait_ticks;
    scl_out_next     = scl_out;
    sda_out_next     = sda_out;
    ack_choice_next  = ack_choice;
    ack_seen_next    = ack_seen;
    go_enter         = 1'b0;
    enter_ph         = PH_IDLE;
    res_next         = '0;

    if (q_op.is_cmd) begin
      if (phase != PH_IDLE) begin
        res_next.cmd_rejected = 1'b1;
      end else begin
        cur_cmd_next    = q_op.cmd;
        bit_index_next  = '0;
        ack_seen_next   = 1'b0;
        wait_ticks_next = '0;
        go_enter        = 1'b1;
        case (q_op.cmd)
          CMD_START: begin
            enter_ph = PH_ST_A;
          end
          CMD_STOP: begin
            enter_ph = PH_SP_A;
          end
          CMD_WRITE: begin
            shift_reg_next = q_op.tx_byte;
            enter_ph       = PH_WR_LOW;
          end
          default: begin
            shift_reg_next  = '0;
            ack_choice_next = q_op.send_ack;
            enter_ph        = PH_RD_LOW;
          end
        endcase
      end
    end else if (q_op.is_tick && phase != PH_IDLE) begin
      if (phase == PH_AK_WAIT) begin
        if (!q_op.sda_in) begin
          ack_seen_next = 1'b1;
          go_enter      = 1'b1;
          enter_ph      = PH_AK_TAIL;
        end else if (wait_ticks >= ack_timeout) begin
          ack_seen_next = 1'b0;
          go_enter      = 1'b1;
          enter_ph      = PH_SP_A;
        end else begin
          wait_ticks_next = wait_ticks + 16'd1;
        end
      end else begin
        phase_ticks_next = ticks_inc;
        if (ticks_inc >= half_period) begin
          case (phase)
            PH_ST_A: begin
              go_enter = 1'b1;
              enter_ph = PH_ST_B;
            end
            PH_ST_B: begin
              go_enter = 1'b1;
              enter_ph = PH_ST_C;
            end
            PH_SP_A: begin
              go_enter = 1'b1;
              enter_ph = PH_SP_B;
            end
            PH_SP_B: begin
              go_enter = 1'b1;
              enter_ph = PH_SP_C;
            end
            PH_ST_C, PH_SP_C: begin
              phase_next         = PH_IDLE;
              res_next.done_res  = 1'b1;
              res_next.timed_out = (cur_cmd == CMD_WRITE);
            end
            PH_WR_LOW: begin
              go_enter = 1'b1;
              enter_ph = PH_WR_HIGH;
            end
            PH_WR_HIGH: begin
              shift_reg_next = {shift_reg[6:0], 1'b0};
              bit_index_next = bit_index + 4'd1;
              go_enter       = 1'b1;
              enter_ph       = (bit_index_next >= 4'd8) ? PH_AK_LOW : PH_WR_LOW;
            end
            PH_RD_LOW: begin
              go_enter = 1'b1;
              enter_ph = PH_RD_HIGH;
            end
            PH_RD_HIGH: begin
              shift_reg_next = {shift_reg[6:0], q_op.sda_in};
              bit_index_next = bit_index + 4'd1;
              go_enter       = 1'b1;
              enter_ph       = (bit_index_next >= 4'd8) ? PH_AK_LOW : PH_RD_LOW;
            end
            PH_AK_LOW: begin
              go_enter = 1'b1;
              enter_ph = PH_AK_HIGH;
            end
            PH_AK_HIGH: begin
              go_enter = 1'b1;
              enter_ph = (cur_cmd == CMD_WRITE) ? PH_AK_WAIT : PH_AK_TAIL;
            end
            PH_AK_TAIL: begin
              phase_next        = PH_IDLE;
              res_next.done_res = 1'b1;
              sda_out_next      = 1'b1;
              if (cur_cmd == CMD_WRITE) begin
                res_next.got_ack = ack_seen;
              end else begin
                res_next.rx_byte = shift_reg;
              end
            end
            default: begin
              phase_next = PH_IDLE;
            end
          endcase
        end
      end
    end

    // phase entry drives the pins for the new phase
    if (go_enter) begin
      phase_next       = enter_ph;
      phase_ticks_next = '0;
      case (enter_ph)
        PH_ST_A: begin
          scl_out_next = 1'b1;
          sda_out_next = 1'b1;
        end
        PH_ST_B: begin
          scl_out_next = 1'b1;
          sda_out_next = 1'b0;
        end
        PH_ST_C, PH_SP_A: begin
          scl_out_next = 1'b0;
          sda_out_next = 1'b0;
        end
        PH_SP_B: begin
          scl_out_next = 1'b1;
          sda_out_next = 1'b0;
        end
        PH_SP_C: begin
          scl_out_next = 1'b1;
          sda_out_next = 1'b1;
        end
        PH_WR_LOW: begin
          scl_out_next = 1'b0;
          sda_out_next = shift_reg_next[7];
        end
        PH_AK_LOW: begin
          scl_out_next = 1'b0;
          sda_out_next = !((cur_cmd_next == CMD_READ) && ack_choice_next);
        end
        PH_AK_WAIT: begin
          scl_out_next    = 1'b1;
          sda_out_next    = 1'b1;
          wait_ticks_next = '0;
        end
        PH_AK_TAIL: begin
          scl_out_next = 1'b0;
        end
        PH_RD_LOW: begin
          scl_out_next = 1'b0;
          sda_out_next = 1'b1;
        end
        PH_WR_HIGH, PH_AK_HIGH, PH_RD_HIGH: begin
          scl_out_next = 1'b1;
        end
        default: begin
          scl_out_next = scl_out;
        end
      endcase
    end

    res_next.scl_level = scl_out_next;
    res_next.sda_drive = sda_out_next;
    res_next.busy_res  = (phase_next != PH_IDLE);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_IDLE;
      cur_cmd     <= CMD_START;
      bit_index   <= '0;
      shift_reg   <= '0;
      phase_ticks <= '0;
      wait_ticks  <= '0;
      scl_out     <= 1'b1;
      sda_out     <= 1'b1;
      ack_choice  <= 1'b0;
      ack_seen    <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      if (q_pop) begin
        phase       <= phase_next;
        cur_cmd     <= cur_cmd_next;
        bit_index   <= bit_index_next;
        shift_reg   <= shift_reg_next;
        phase_ticks <= phase_ticks_next;
        wait_ticks  <= wait_ticks_next;
        scl_out     <= scl_out_next;
        sda_out     <= sda_out_next;
        ack_choice  <= ack_choice_next;
        ack_seen    <= ack_seen_next;
        out_valid   <= 1'b1;
      end else if (out_ready) begin
        out_valid   <= 1'b0;
      end
    end
  end

  // result register, payload only
  always_ff @(posedge clk) begin
    if (q_pop) begin
      out_res <= res_next;
    end
  end

endmodule

### hw/rtl/i2c_master_bit_engine_unit.sv
// ----------------------------------------------------------------------------
// i2c_master_bit_engine_unit
// i2c master bit engine: front classifier, beat queue, bit-phase sequencer
//
//   channel  direction  signals                      beat
//   s        in         s_tvalid s_tready s_tdata    one request or tick
//                       s_tuser
//   m        out        m_tvalid m_tready m_tdata    one result per input beat
//   cfg      in         cfg_valid cfg_ready          one register write
//                       cfg_index cfg_data
//
// one beat per cycle sustained while m_tready holds; the engine updates all
// sequencer state for each beat it takes and writes its result into the output
// register; an input beat is held in a queue slot, then in the result register
// a stalled m side fills the queue, after which s_tready drops
// rst is synchronous: pins released, sequencer idle, queue and output empty
// cfg_ready is always high; writes apply to the next beat the engine takes
// ----------------------------------------------------------------------------
`include "i2c_master_bit_engine_unit_macros.svh"

module i2c_master_bit_engine_unit #(
  parameter int QUEUE_DEPTH = i2cm_pkg::QUEUE_DEPTH
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,   // tx_byte[7:0], send_ack[8], sda_in[9], zero[15:10]
  input  logic [2:0]  s_tuser,   // req_type[2:0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,   // scl_level[0], sda_drive[1], busy_res[2], done_res[3],
                                 // got_ack[4], timed_out[5], rx_byte[13:6],
                                 // cmd_rejected[14], zero[15]
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [15:0] cfg_data
);
  import i2cm_pkg::*;

  logic [7:0]  half_period;
  logic [15:0] ack_timeout;
  logic        q_push;
  logic        q_full;
  logic        q_pop;
  logic        q_valid;
  op_t         q_in;
  op_t         q_out;
  res_t        res;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      half_period <= HALF_PERIOD_RST;
      ack_timeout <= ACK_TIMEOUT_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_HALF_PERIOD: half_period <= cfg_data[7:0];
        CFG_ACK_TIMEOUT: ack_timeout <= cfg_data;
        default:         half_period <= half_period;
      endcase
    end
  end

  i2cm_front u_front (
    .valid  (s_tvalid),
    .ready  (s_tready),
    .data   (s_tdata),
    .kind   (s_tuser),
    .q_push (q_push),
    .q_op   (q_in),
    .q_full (q_full)
  );

  i2cm_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .wr_data   (q_in),
    .full      (q_full),
    .pop       (q_pop),
    .rd_data   (q_out),
    .not_empty (q_valid)
  );

  i2cm_engine u_engine (
    .clk         (clk),
    .rst         (rst),
    .half_period (half_period),
    .ack_timeout (ack_timeout),
    .q_valid     (q_valid),
    .q_op        (q_out),
    .q_pop       (q_pop),
    .out_valid   (m_tvalid),
    .out_ready   (m_tready),
    .out_res     (res)
  );

  assign m_tdata = {1'b0, res.cmd_rejected, res.rx_byte, res.timed_out, res.got_ack,
                    res.done_res, res.busy_res, res.sda_drive, res.scl_level};

  `I2CM_ASSERT_NEXT(a_pop_fills_output, clk, rst, q_pop, m_tvalid, "engine took a beat but no result followed")
  `I2CM_ASSERT_NOW(a_reject_while_busy, clk, rst, m_tvalid && res.cmd_rejected, res.busy_res, "command rejected while idle")
  `I2CM_ASSERT_NOW(a_timeout_ends_write, clk, rst, m_tvalid && res.timed_out, res.done_res && !res.got_ack, "timeout without completion or with ack")
  `I2CM_ASSERT_NOW(a_rx_only_on_done, clk, rst, m_tvalid && (res.rx_byte != 8'd0), res.done_res && !res.busy_res, "received byte shown outside completion")

endmodule
